// ----- src/tsi_pkg.sv -----
// package for the table search interpolator: types, constants, codes
// no dependencies
package tsi_pkg;
  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned IdxW = $clog2(TableDepthDef);
  localparam int unsigned CountW = IdxW + 1;
  localparam int unsigned FracW = FracBitsDef;

  typedef enum logic [0:0] {CMD_WRITE = 1'b0, CMD_QUERY = 1'b1} cmd_e;
  typedef enum logic [1:0] {
    MODE_PREV = 2'd0, MODE_NEXT = 2'd1, MODE_CLOSEST = 2'd2, MODE_LINEAR = 2'd3
  } mode_e;
  localparam logic [0:0] REG_MODE = 1'b0;
  localparam logic [0:0] REG_COUNT = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [IdxW-1:0]   entry_index;
    logic signed [31:0] position;
    logic signed [31:0] sample_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [IdxW-1:0]   base_index;
    logic [FracW-1:0]  fraction;
    logic              below_range;
    logic              above_range;
  } rsp_t;
endpackage

// ----- src/tsi_ram.sv -----
// generic single port synchronous ram, registered read
// no dependencies
module tsi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ----- src/tsi_div.sv -----
// restoring divider for the fraction: floor(num * 2^F / den), one bit per cycle
// depends on nothing; num < den guaranteed by caller
module tsi_div #(
  parameter int unsigned FracBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [32:0]         num_i,
  input  logic [32:0]         den_i,
  output logic                done_o,
  output logic [FracBits-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(FracBits + 1);
  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q;
  logic [FracBits-1:0] quot_q;
  logic [CntW-1:0] cnt_q;
  logic busy_q;
  logic [33:0] trial;

  always_comb begin
    rem_d = {rem_q[32:0], 1'b0};
    trial = rem_d - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= CntW'(FracBits);
        rem_q <= {1'b0, num_i};
        den_q <= den_i;
      end else if (busy_q) begin
        if (!trial[33]) begin
          rem_q <= trial;
          quot_q <= {quot_q[FracBits-2:0], 1'b1};
        end else begin
          rem_q <= rem_d;
          quot_q <= {quot_q[FracBits-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
  assign quot_o = quot_q;
endmodule

// ----- src/table_search_interpolator_top.sv -----
// top level of the table search interpolator: sequencer, two table rams, divider
// depends on tsi_pkg, tsi_ram, tsi_div
//
// channel   dir  payload  handshake
// req       in   req_t    req_valid_i / req_stall_o
// rsp       out  rsp_t    rsp_valid_o / rsp_stall_i
// cfg       in   32 bits  cfg_we_i, cfg_index_i
//
// a write request is taken in idle and its ram write is registered. a query
// inside the span runs k bisection steps (about log2(entry_count - 1)), then
// the bit-serial divider unless the fraction is trivial; a clamped query ends
// at the first or last entry read. the read address shared by both rams for
// every step and the divider set a query's length. reset clears control, sets
// mode linear and count one; data and table contents stay undefined. a result
// waits in the output register; the next request is still taken, and its own
// result holds at the output stage until the register is free.
module table_search_interpolator_top
  import tsi_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  tsi_pkg::req_t req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output tsi_pkg::rsp_t rsp_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned NW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_FIRST, S_WT_FIRST, S_RD_LAST, S_WT_LAST, S_CHK_LAST,
    S_MID, S_MID_WT, S_MID_CMP, S_RD_X0, S_RD_X1, S_DIV, S_DIV_WT,
    S_MUL, S_OUT
  } state_e;

  state_e state_q;
  logic [1:0] mode_q;
  logic [CountW-1:0] count_q;
  logic [NW-1:0] n_eff;
  logic [AW-1:0] lo_q, hi_q, addr_q;
  logic signed [31:0] pos_q, x0_q, y0_q, y1_q, res_q;
  logic [FracBits-1:0] frac_q;
  logic below_q, above_q, we_q, div_start_q;
  logic [31:0] bp_rd, val_rd;
  logic div_done;
  logic [FracBits-1:0] div_q;
  logic [AW-1:0] mid;
  logic signed [32:0] dt, num;
  logic signed [33+FracBits:0] prod_q;
  logic sel_up;
  logic [31:0] wr_bp_q, wr_val_q;

  // effective count: 0 acts as 1, large values clip to depth
  always_comb begin
    if (count_q == '0) n_eff = NW'(1);
    else if (32'(count_q) > TableDepth) n_eff = NW'(TableDepth);
    else n_eff = NW'(count_q);
  end
  assign mid = AW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

  tsi_ram #(.Width(32), .Depth(TableDepth)) u_bp (
    .clk_i, .we_i(we_q), .addr_i(addr_q), .wdata_i(wr_bp_q), .rdata_o(bp_rd));
  tsi_ram #(.Width(32), .Depth(TableDepth)) u_val (
    .clk_i, .we_i(we_q), .addr_i(addr_q), .wdata_i(wr_val_q), .rdata_o(val_rd));

  tsi_div #(.FracBits(FracBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start_q), .num_i(num), .den_i(dt),
    .done_o(div_done), .quot_o(div_q));

  assign dt = 33'(signed'(bp_rd)) - 33'(x0_q);
  assign num = 33'(pos_q) - 33'(x0_q);

  always_comb begin
    case (mode_e'(mode_q))
      MODE_NEXT:    sel_up = (frac_q != '0);
      MODE_CLOSEST: sel_up = frac_q[FracBits-1];
      default:      sel_up = 1'b0;
    endcase
  end

  // the output register parts the sides: a waiting result does not block input
  assign req_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= MODE_LINEAR;
      count_q <= CountW'(1);
      rsp_valid_o <= 1'b0;
      we_q <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      we_q <= 1'b0;
      div_start_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == REG_MODE) mode_q <= cfg_data_i[1:0];
        else count_q <= cfg_data_i[CountW-1:0];
      end
      if (rsp_valid_o && !rsp_stall_i) rsp_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_valid_i && !req_stall_o) begin
            pos_q <= req_i.position;
            if (req_i.cmd == CMD_WRITE) begin
              // index beyond depth is dropped
              if (32'(req_i.entry_index) < TableDepth) begin
                we_q <= 1'b1;
                addr_q <= AW'(req_i.entry_index);
                wr_bp_q <= req_i.position;
                wr_val_q <= req_i.sample_value;
              end
            end else begin
              addr_q <= '0;
              state_q <= S_RD_FIRST;
            end
          end
        end
        S_RD_FIRST: state_q <= S_WT_FIRST;
        S_WT_FIRST: begin
          below_q <= 1'b0;
          above_q <= 1'b0;
          frac_q <= '0;
          if (pos_q <= signed'(bp_rd)) begin
            below_q <= 1'b1;
            lo_q <= '0;
            res_q <= val_rd;
            state_q <= S_OUT;
          end else begin
            addr_q <= AW'(n_eff - 1'b1);
            state_q <= S_RD_LAST;
          end
        end
        S_RD_LAST: state_q <= S_WT_LAST;
        S_WT_LAST: state_q <= S_CHK_LAST;
        S_CHK_LAST: begin
          if (pos_q >= signed'(bp_rd)) begin
            above_q <= 1'b1;
            lo_q <= addr_q;
            res_q <= val_rd;
            state_q <= S_OUT;
          end else begin
            lo_q <= '0;
            hi_q <= addr_q;
            state_q <= S_MID;
          end
        end
        S_MID: begin
          if ({1'b0, hi_q} - {1'b0, lo_q} > (AW+1)'(1)) begin
            addr_q <= mid;
            state_q <= S_MID_WT;
          end else begin
            addr_q <= lo_q;
            state_q <= S_RD_X0;
          end
        end
        S_MID_WT: state_q <= S_MID_CMP;
        S_MID_CMP: begin
          if (signed'(bp_rd) <= pos_q) lo_q <= addr_q;
          else hi_q <= addr_q;
          state_q <= S_MID;
        end
        S_RD_X0: begin
          addr_q <= lo_q + 1'b1;
          state_q <= S_RD_X1;
        end
        S_RD_X1: begin
          // data of lo now on the read port
          x0_q <= bp_rd;
          y0_q <= val_rd;
          state_q <= S_DIV;
        end
        S_DIV: begin
          y1_q <= val_rd;
          if (dt > 0 && num > 0) begin
            if (num >= dt) begin
              frac_q <= '1;
              state_q <= S_MUL;
            end else begin
              div_start_q <= 1'b1;
              state_q <= S_DIV_WT;
            end
          end else begin
            frac_q <= '0;
            state_q <= S_MUL;
          end
        end
        S_DIV_WT: begin
          if (div_done) begin
            frac_q <= div_q;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q <= (34+FracBits)'(signed'({1'b0, frac_q}))
                  * (34+FracBits)'(33'(y1_q) - 33'(y0_q));
          state_q <= S_OUT;
          if (mode_e'(mode_q) != MODE_LINEAR) begin
            res_q <= sel_up ? y1_q : y0_q;
          end
        end
        S_OUT: begin
          if (!rsp_valid_o) begin
            rsp_valid_o <= 1'b1;
            rsp_o.result_value <= (!below_q && !above_q
                && mode_e'(mode_q) == MODE_LINEAR)
                ? y0_q + 32'(prod_q >>> FracBits) : res_q;
            rsp_o.base_index <= IdxW'(lo_q);
            rsp_o.fraction <= FracW'(frac_q);
            rsp_o.below_range <= below_q;
            rsp_o.above_range <= above_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
